// ----- rtl/gpqm_pkg.sv -----
// ============================================================================
// Greedy plane quad mesher: shared package
// Command and status bundles between the controller and the datapath,
// register indexes of the configuration port and fixed scan widths.
// ============================================================================
package gpqm_pkg;

    // Register indexes on the configuration port.
    localparam logic [2:0] CFG_FACE_NORMAL = 3'd0;
    localparam logic [2:0] CFG_PLANE_COORD = 3'd1;
    localparam logic [2:0] CFG_MATERIAL_ID = 3'd2;
    localparam logic [2:0] CFG_ACROSS_AXIS = 3'd3;
    localparam logic [2:0] CFG_ALONG_AXIS  = 3'd4;
    localparam logic [2:0] CFG_DEPTH_AXIS  = 3'd5;

    // Normals from this value upward swap width and height.
    localparam logic [2:0] NORMAL_SWAP_MIN = 3'd2;

    // Widest vector that the find-first-one encoder sees (row plus carry out).
    localparam int SCAN_W = 65;
    localparam int IDX_W  = 7;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // write one row from the input transfer
        logic find;        // latch the lowest occupied row and the empty flag
        logic read_first;  // read the lowest occupied row
        logic analyse;     // lowest set bit and carry sum of that row
        logic start_run;   // clear the run in the first row, read the next row
        logic extend;      // test one following row, clear the run in it if it holds the run
        logic emit;        // load the output register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;       // plane held no set bit at the take
        logic v_at_end;    // first row is the last row of the plane
        logic r_at_end;    // row under test is the last row of the plane
        logic contained;   // row under test holds the whole run
        logic out_free;    // output register can take a result this cycle
    } status_t;

endpackage

// ----- rtl/gpqm_ctrl.sv -----
// ============================================================================
// Greedy plane quad mesher: controller
// Sequences a take item through row read, run analysis, downward extension
// and result hand-off. Load items complete in the cycle they are accepted.
// ============================================================================
module gpqm_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              kind,
    input  gpqm_pkg::status_t status,
    output gpqm_pkg::cmd_t    cmd
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_READ = 6'b000010,
        S_LOW  = 6'b000100,
        S_RUN  = 6'b001000,
        S_EXT  = 6'b010000,
        S_EMIT = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (kind)
                    begin
                        cmd.find   = 1'b1;
                        state_next = S_READ;
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                    end
                end
            end
            S_READ:
            begin
                if (status.empty)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.read_first = 1'b1;
                    state_next     = S_LOW;
                end
            end
            S_LOW:
            begin
                cmd.analyse = 1'b1;
                state_next  = S_RUN;
            end
            S_RUN:
            begin
                cmd.start_run = 1'b1;
                state_next    = status.v_at_end ? S_EMIT : S_EXT;
            end
            S_EXT:
            begin
                cmd.extend = 1'b1;
                if (!status.contained || status.r_at_end)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/gpqm_dp.sv -----
// ============================================================================
// Greedy plane quad mesher: datapath
// Plane memory with per-row occupancy flags, run finder, extension compare,
// configuration registers and the output register.
// ============================================================================
module gpqm_dp
#(
    parameter int ROW_COUNT = 64,
    parameter int ROW_WIDTH = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  gpqm_pkg::cmd_t    cmd,
    output gpqm_pkg::status_t status,
    input  logic [5:0]        row_number,
    input  logic [63:0]       row_bits,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [7:0]        cfg_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              found,
    output logic [5:0]        face_x,
    output logic [5:0]        face_y,
    output logic [5:0]        face_z,
    output logic [6:0]        face_width,
    output logic [6:0]        face_height,
    output logic [2:0]        face_dir,
    output logic [7:0]        face_material
);

    localparam int RW = $clog2(ROW_COUNT);
    localparam int UW = $clog2(ROW_WIDTH);

    // Index of the lowest set bit; the caller guarantees a set bit where it matters.
    function automatic logic [gpqm_pkg::IDX_W-1:0] lowest_one(
        input logic [gpqm_pkg::SCAN_W-1:0] x
    );
        logic [gpqm_pkg::IDX_W-1:0] idx;
        idx = '0;
        for (int i = gpqm_pkg::SCAN_W - 1; i >= 0; i--)
        begin
            if (x[i])
            begin
                idx = gpqm_pkg::IDX_W'(i);
            end
        end
        return idx;
    endfunction

    // Plane storage and occupancy flags. A row whose flag is clear is treated as empty.
    logic [ROW_WIDTH-1:0] mem [ROW_COUNT];
    logic [ROW_COUNT-1:0] nz_reg;
    logic [ROW_WIDTH-1:0] rd_data_reg;
    logic                 rd_nz_reg;

    // Configuration registers.
    logic [2:0] face_normal_reg;
    logic [5:0] plane_coord_reg;
    logic [7:0] material_id_reg;
    logic [1:0] across_axis_reg;
    logic [1:0] along_axis_reg;
    logic [1:0] depth_axis_reg;

    // Working registers of one take.
    logic                 empty_reg;
    logic [RW-1:0]        v_reg;
    logic [RW-1:0]        r_reg;
    logic [UW-1:0]        u_reg;
    logic [ROW_WIDTH:0]   sum_reg;
    logic [ROW_WIDTH-1:0] run_reg;
    logic [6:0]           w_reg;
    logic [6:0]           h_reg;

    // Output register.
    logic       out_valid_reg;
    logic       found_reg;
    logic [5:0] face_x_reg;
    logic [5:0] face_y_reg;
    logic [5:0] face_z_reg;
    logic [6:0] face_width_reg;
    logic [6:0] face_height_reg;
    logic [2:0] face_dir_reg;
    logic [7:0] face_material_reg;

    logic [gpqm_pkg::IDX_W-1:0] v_scan;
    logic [gpqm_pkg::IDX_W-1:0] u_scan;
    logic [gpqm_pkg::IDX_W-1:0] end_scan;
    logic [ROW_WIDTH-1:0]       lowbit;
    logic [ROW_WIDTH:0]         sum_next;
    logic [ROW_WIDTH-1:0]       run_next;
    logic                       contained;
    logic                       v_at_end;
    logic                       r_at_end;
    logic                       row_in_range;
    logic                       wr_en;
    logic [RW-1:0]              wr_addr;
    logic [ROW_WIDTH-1:0]       wr_data;
    logic                       rd_en;
    logic [RW-1:0]              rd_addr;
    logic [5:0]                 coord [3];
    logic                       swap;

    assign v_scan   = lowest_one(gpqm_pkg::SCAN_W'(nz_reg));
    assign u_scan   = lowest_one(gpqm_pkg::SCAN_W'(rd_data_reg));
    assign end_scan = lowest_one(gpqm_pkg::SCAN_W'(sum_reg));

    // Adding the lowest set bit ripples through the run, so the sum's lowest
    // set bit marks the first position past the run.
    assign lowbit   = rd_data_reg & (~rd_data_reg + ROW_WIDTH'(1));
    assign sum_next = {1'b0, rd_data_reg} + {1'b0, lowbit};
    assign run_next = rd_data_reg & ~sum_reg[ROW_WIDTH-1:0];

    assign contained    = rd_nz_reg && ((rd_data_reg & run_reg) == run_reg);
    assign v_at_end     = (v_reg == RW'(ROW_COUNT - 1));
    assign r_at_end     = (r_reg == RW'(ROW_COUNT - 1));
    assign row_in_range = ({1'b0, row_number} < 7'(ROW_COUNT));

    assign status.empty     = empty_reg;
    assign status.v_at_end  = v_at_end;
    assign status.r_at_end  = r_at_end;
    assign status.contained = contained;
    assign status.out_free  = !out_valid_reg || out_ready;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = v_reg;
        wr_data = rd_data_reg & ~run_next;
        if (cmd.load)
        begin
            wr_en   = row_in_range;
            wr_addr = row_number[RW-1:0];
            wr_data = row_bits[ROW_WIDTH-1:0];
        end
        else if (cmd.start_run)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.extend)
        begin
            wr_en   = contained;
            wr_addr = r_reg;
            wr_data = rd_data_reg & ~run_reg;
        end
    end

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = v_reg;
        if (cmd.read_first)
        begin
            rd_en = 1'b1;
        end
        else if (cmd.start_run)
        begin
            rd_en   = !v_at_end;
            rd_addr = v_reg + RW'(1);
        end
        else if (cmd.extend)
        begin
            rd_en   = contained && !r_at_end;
            rd_addr = r_reg + RW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Coordinate placement: across, then along, then depth; a later axis wins.
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            coord[a] = '0;
            if (across_axis_reg == 2'(a))
            begin
                coord[a] = 6'(u_reg);
            end
            if (along_axis_reg == 2'(a))
            begin
                coord[a] = 6'(v_reg);
            end
            if (depth_axis_reg == 2'(a))
            begin
                coord[a] = plane_coord_reg;
            end
        end
    end

    assign swap = (face_normal_reg >= gpqm_pkg::NORMAL_SWAP_MIN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nz_reg          <= '0;
            rd_nz_reg       <= 1'b0;
            empty_reg       <= 1'b1;
            out_valid_reg   <= 1'b0;
            face_normal_reg <= 3'd0;
            plane_coord_reg <= 6'd0;
            material_id_reg <= 8'd0;
            across_axis_reg <= 2'd1;
            along_axis_reg  <= 2'd2;
            depth_axis_reg  <= 2'd0;
        end
        else
        begin
            if (wr_en)
            begin
                nz_reg[wr_addr] <= |wr_data;
            end
            if (rd_en)
            begin
                rd_nz_reg <= nz_reg[rd_addr];
            end
            if (cmd.find)
            begin
                empty_reg <= ~|nz_reg;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    gpqm_pkg::CFG_FACE_NORMAL: face_normal_reg <= cfg_data[2:0];
                    gpqm_pkg::CFG_PLANE_COORD: plane_coord_reg <= cfg_data[5:0];
                    gpqm_pkg::CFG_MATERIAL_ID: material_id_reg <= cfg_data;
                    gpqm_pkg::CFG_ACROSS_AXIS: across_axis_reg <= cfg_data[1:0];
                    gpqm_pkg::CFG_ALONG_AXIS:  along_axis_reg  <= cfg_data[1:0];
                    gpqm_pkg::CFG_DEPTH_AXIS:  depth_axis_reg  <= cfg_data[1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.find)
        begin
            v_reg <= v_scan[RW-1:0];
        end
        if (cmd.analyse)
        begin
            u_reg   <= u_scan[UW-1:0];
            sum_reg <= sum_next;
        end
        if (cmd.start_run)
        begin
            run_reg <= run_next;
            w_reg   <= end_scan - 7'(u_reg);
            h_reg   <= 7'd1;
            r_reg   <= v_reg + RW'(1);
        end
        if (cmd.extend && contained)
        begin
            h_reg <= h_reg + 7'd1;
            r_reg <= r_reg + RW'(1);
        end
        if (cmd.emit)
        begin
            found_reg <= !empty_reg;
            if (empty_reg)
            begin
                face_x_reg        <= '0;
                face_y_reg        <= '0;
                face_z_reg        <= '0;
                face_width_reg    <= '0;
                face_height_reg   <= '0;
                face_dir_reg      <= '0;
                face_material_reg <= '0;
            end
            else
            begin
                face_x_reg        <= coord[0];
                face_y_reg        <= coord[1];
                face_z_reg        <= coord[2];
                face_width_reg    <= swap ? h_reg : w_reg;
                face_height_reg   <= swap ? w_reg : h_reg;
                face_dir_reg      <= face_normal_reg;
                face_material_reg <= material_id_reg;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign found         = found_reg;
    assign face_x        = face_x_reg;
    assign face_y        = face_y_reg;
    assign face_z        = face_z_reg;
    assign face_width    = face_width_reg;
    assign face_height   = face_height_reg;
    assign face_dir      = face_dir_reg;
    assign face_material = face_material_reg;

endmodule

// ----- rtl/greedy_plane_quad_mesher_top.sv -----
// ============================================================================
// Greedy plane quad mesher: top level
// Holds a ROW_COUNT by ROW_WIDTH occupancy plane and peels greedy quads off
// it, one face per take item.
// ============================================================================
// A load item (kind 0) overwrites one row of the plane in the cycle of its
// transfer and gives no result; rows at or beyond ROW_COUNT are ignored and
// bits at or above ROW_WIDTH are dropped. A take item (kind 1) finds the
// lowest occupied row, the lowest set bit in it and the run of set bits above
// that bit, then grows the face downward while each following row holds the
// whole run, clearing the covered bits as it goes, and returns one face; on
// an empty plane it returns found = 0 with every other field zero. The
// extension compares one row per cycle against a plane memory with one
// write port and one registered read port. A take keeps the input closed
// from its transfer until its face is loaded: the lowest occupied row is
// found and read, its run is analysed and cleared, then the following rows
// are examined (the face height, or one less when the face reaches the
// last row); an empty plane skips these steps. A finished face sits in an
// output register, so the block returns to accepting input as soon as the
// face is loaded there, and it waits only if an earlier face has not yet been
// taken. Configuration writes are accepted in every cycle and must only be
// issued while no take is in progress. There is no clearing pass after reset:
// a per-row occupancy flag, cleared by reset, makes unwritten rows read as
// empty.
module greedy_plane_quad_mesher_top
#(
    parameter int ROW_COUNT = 64,
    parameter int ROW_WIDTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,

    // Item channel.
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [5:0]  row_number,
    input  logic [63:0] row_bits,

    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data,

    // Result channel.
    output logic        out_valid,
    input  logic        out_ready,
    output logic        found,
    output logic [5:0]  face_x,
    output logic [5:0]  face_y,
    output logic [5:0]  face_z,
    output logic [6:0]  face_width,
    output logic [6:0]  face_height,
    output logic [2:0]  face_dir,
    output logic [7:0]  face_material
);

    gpqm_pkg::cmd_t    cmd;
    gpqm_pkg::status_t status;

    // The controller decides the order of the steps; it sees the datapath
    // only through the status bundle.
    gpqm_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .kind     (kind),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath owns the plane memory, the configuration registers and
    // the output register.
    gpqm_dp
    #(
        .ROW_COUNT (ROW_COUNT),
        .ROW_WIDTH (ROW_WIDTH)
    )
    u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .row_number    (row_number),
        .row_bits      (row_bits),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .found         (found),
        .face_x        (face_x),
        .face_y        (face_y),
        .face_z        (face_z),
        .face_width    (face_width),
        .face_height   (face_height),
        .face_dir      (face_dir),
        .face_material (face_material)
    );

endmodule

// ----- rtl/gpqm_checker.sv -----
// ============================================================================
// Greedy plane quad mesher: port checker
// Watches the top level's ports for result consistency and take sequencing.
// ============================================================================
module gpqm_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        kind,
    input logic        out_valid,
    input logic        out_ready,
    input logic        found,
    input logic [5:0]  face_x,
    input logic [5:0]  face_y,
    input logic [5:0]  face_z,
    input logic [6:0]  face_width,
    input logic [6:0]  face_height,
    input logic [2:0]  face_dir,
    input logic [7:0]  face_material
);

    // An empty-plane result carries nothing but zeros.
    a_empty_is_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |->
            (face_x == 6'd0 && face_y == 6'd0 && face_z == 6'd0 &&
             face_width == 7'd0 && face_height == 7'd0 &&
             face_dir == 3'd0 && face_material == 8'd0)
    ) else $error("empty result with nonzero fields");

    // A found face covers at least one cell and no more than a full plane side.
    a_face_size: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && found) |->
            (face_width != 7'd0 && face_height != 7'd0 &&
             face_width <= 7'd64 && face_height <= 7'd64)
    ) else $error("face size out of range");

    // A take keeps the input closed in the following cycle.
    a_take_blocks: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && kind) |=> !in_ready
    ) else $error("input accepted during a take");

    // A stalled result holds its payload.
    a_out_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(found) && $stable(face_x) && $stable(face_y) &&
             $stable(face_z) && $stable(face_width) && $stable(face_height) &&
             $stable(face_dir) && $stable(face_material))
    ) else $error("stalled result changed");

endmodule

bind greedy_plane_quad_mesher_top gpqm_checker u_gpqm_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .found         (found),
    .face_x        (face_x),
    .face_y        (face_y),
    .face_z        (face_z),
    .face_width    (face_width),
    .face_height   (face_height),
    .face_dir      (face_dir),
    .face_material (face_material)
);
